[rtl/cbhm_pkg.sv]
package cbhm_pkg;

   localparam int ID_SLOTS   = 16;
   localparam int SLOT_BITS  = 4;
   localparam int RING_DEPTH = 64;
   localparam int RING_BITS  = 6;
   localparam int FILL_BITS  = 7;
   localparam int MEM_BITS   = SLOT_BITS + RING_BITS;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] CSR_DEADLINE    = 3'd0;
   localparam logic [2:0] CSR_CORR_WINDOW = 3'd1;
   localparam logic [2:0] CSR_CORR_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_FLOOD_WIN   = 3'd3;
   localparam logic [2:0] CSR_FLOOD_LIMIT = 3'd4;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_DROPOUT = 2'd1;
   localparam logic [1:0] FAULT_CORRUPT = 2'd2;
   localparam logic [1:0] FAULT_FLOOD   = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [31:0] now_us;
      logic [28:0] can_id;
      logic        error_frame;
      logic [3:0]  dlc;
   } req_type;

   typedef struct packed {
      logic        degraded;
      logic [1:0]  fault_code;
      logic [31:0] fault_event_count;
      logic [10:0] bus_frame_count;
      logic [16:0] peak_ratio;
      logic        table_overflow;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic        eval;
      logic [31:0] now;
      logic [28:0] can_id;
      logic        invalid;
   } cmd_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] corr_window;
      logic [16:0] corr_limit;
      logic [31:0] flood_window;
      logic [6:0]  flood_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MATCH, ST_STAMP, ST_SLOT, ST_READ, ST_ACC,
      ST_DIV, ST_SLOT_END, ST_DONE
   } back_state_type;

endpackage

[rtl/cbhm_front.sv]
module cbhm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cbhm_pkg::req_type req_data,
   output logic              cmd_valid,
   output cbhm_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);
   import cbhm_pkg::*;

   cmd_type          q_ff [QUEUE_DEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   cmd_type          cmd_new;

   assign busy = (cnt_ff == 2'(QUEUE_DEPTH));
   assign push = start && !busy;

   always_comb begin
      cmd_new.eval    = req_data.mode;
      cmd_new.now     = req_data.now_us;
      cmd_new.can_id  = req_data.can_id;
      cmd_new.invalid = req_data.error_frame || (req_data.dlc > 4'd8);
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = cmd_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> cmd_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (busy && !cmd_pop) |=> busy)
      else $error("full queue drained without pop");

endmodule

[rtl/cbhm_divider.sv]
module cbhm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [6:0]  inv,
   input  logic [6:0]  tot,
   output logic        done,
   output logic [16:0] quot
);
   import cbhm_pkg::*;

   // Restoring division of inv<<16 by tot, one quotient bit per cycle.
   logic [22:0] num_ff, num_in;
   logic [7:0]  rem_ff, rem_in;
   logic [6:0]  den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [7:0]  trial;

   assign trial = {rem_ff[6:0], num_ff[22]};
   assign quot  = num_ff[16:0];
   assign done  = run_ff && (cnt_ff == 5'd0);

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (go) begin
         num_in = {inv, 16'd0};
         rem_in = 8'd0;
         den_in = tot;
         cnt_in = 5'd23;
         run_in = 1'b1;
      end else if (run_ff && cnt_ff != 5'd0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[21:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[21:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
      end else if (done) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
         run_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         run_ff <= run_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) go |=> run_ff && cnt_ff == 5'd23)
      else $error("divider did not start");

endmodule

[rtl/cbhm_back.sv]
module cbhm_back (
   input  logic              clock,
   input  logic              reset,
   input  cbhm_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  cbhm_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output cbhm_pkg::rsp_type rsp_data
);
   import cbhm_pkg::*;

   back_state_type   state_ff, state_in;

   logic [ID_SLOTS-1:0]  used_ff, used_in;
   logic [ID_SLOTS-1:0]  drop_ff, drop_in;
   logic [28:0]          id_ff   [ID_SLOTS];
   logic [31:0]          seen_ff [ID_SLOTS];
   logic [RING_BITS-1:0] head_ff [ID_SLOTS];
   logic [FILL_BITS-1:0] fill_ff [ID_SLOTS];
   logic [31:0]          fault_cnt_ff, fault_cnt_in;
   logic                 ovf_ff, ovf_in;

   // Ring memory: one write or one read per cycle, registered read data
   logic [32:0]          ring_mem [ID_SLOTS*RING_DEPTH];
   logic [32:0]          rd_ff;

   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [FILL_BITS-1:0] k_ff, k_in;
   logic                 found_ff, found_in;
   logic                 have_free_ff, have_free_in;
   logic [SLOT_BITS-1:0] free_ff, free_in;
   logic [FILL_BITS-1:0] tot_ff, tot_in, inv_ff, inv_in, fl_ff, fl_in;
   logic                 deg_ff, deg_in;
   logic [1:0]           fault_ff, fault_in;
   logic [11:0]          bus_ff, bus_in;
   logic [16:0]          max_ff, max_in;

   logic                 mem_we, mem_re;
   logic [MEM_BITS-1:0]  mem_addr;
   logic                 div_go, div_done;
   logic [16:0]          div_q, ratio;
   logic [31:0]          age, seen_age;
   logic                 last_slot, is_match;
   logic [31:0]          cnt_bump;

   assign last_slot = (slot_ff == SLOT_BITS'(ID_SLOTS - 1));
   assign is_match  = used_ff[slot_ff] && (id_ff[slot_ff] == cmd_data.can_id);
   assign age       = cmd_data.now - rd_ff[32:1];
   assign seen_age  = cmd_data.now - seen_ff[slot_ff];
   assign cnt_bump  = (fault_cnt_ff == 32'hFFFF_FFFF) ? fault_cnt_ff : fault_cnt_ff + 32'd1;
   assign ratio     = (tot_ff == '0) ? 17'd0 : div_q;

   // Counts are taken as they stand after the last entry is accumulated
   cbhm_divider u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .inv   (inv_in),
      .tot   (tot_in),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (cmd_valid) state_in = cmd_data.eval ? ST_SLOT : ST_MATCH;
         ST_MATCH:    if (is_match || last_slot) state_in = ST_STAMP;
         ST_STAMP:    state_in = ST_DONE;
         ST_SLOT:     state_in = !used_ff[slot_ff] ? ST_SLOT_END :
                                 (fill_ff[slot_ff] == '0) ? ST_DIV : ST_READ;
         ST_READ:     state_in = ST_ACC;
         ST_ACC:      state_in = (k_ff == fill_ff[slot_ff]) ? ST_DIV : ST_READ;
         ST_DIV:      if (div_done || tot_ff == '0) state_in = ST_SLOT_END;
         ST_SLOT_END: state_in = last_slot ? ST_DONE : ST_SLOT;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      used_in = used_ff; drop_in = drop_ff;
      fault_cnt_in = fault_cnt_ff; ovf_in = ovf_ff;
      slot_in = slot_ff; k_in = k_ff;
      found_in = found_ff; have_free_in = have_free_ff; free_in = free_ff;
      tot_in = tot_ff; inv_in = inv_ff; fl_in = fl_ff;
      deg_in = deg_ff; fault_in = fault_ff; bus_in = bus_ff; max_in = max_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_addr = {slot_ff, k_ff[RING_BITS-1:0]};
      div_go = 1'b0; cmd_pop = 1'b0; rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            slot_in = '0; found_in = 1'b0; have_free_in = 1'b0;
            deg_in = 1'b0; fault_in = FAULT_NONE; bus_in = '0; max_in = '0;
         end
         ST_MATCH: begin
            if (is_match) begin
               found_in = 1'b1; free_in = slot_ff;
            end else begin
               if (!used_ff[slot_ff] && !have_free_ff) begin
                  have_free_in = 1'b1; free_in = slot_ff;
               end
               if (!last_slot) slot_in = slot_ff + 1'b1;
            end
         end
         ST_STAMP: begin
            if (found_ff || have_free_ff) begin
               if (!found_ff) begin
                  used_in[free_ff] = 1'b1;
                  drop_in[free_ff] = 1'b0;
               end else if (drop_ff[free_ff]) begin
                  drop_in[free_ff] = 1'b0;
                  fault_cnt_in = cnt_bump;
               end
               mem_we = 1'b1;
               mem_addr = {free_ff, found_ff ? head_ff[free_ff] : RING_BITS'(0)};
            end else begin
               ovf_in = 1'b1;
            end
         end
         ST_SLOT: begin
            k_in = '0; tot_in = '0; inv_in = '0; fl_in = '0;
            if (used_ff[slot_ff]) begin
               if (!drop_ff[slot_ff] && seen_age > cfg.deadline) begin
                  drop_in[slot_ff] = 1'b1;
                  deg_in = 1'b1; fault_in = FAULT_DROPOUT;
                  fault_cnt_in = cnt_bump;
               end else if (drop_ff[slot_ff]) begin
                  deg_in = 1'b1; fault_in = FAULT_DROPOUT;
               end
            end
         end
         ST_READ: begin
            mem_re = 1'b1;
            k_in = k_ff + 1'b1;
         end
         ST_ACC: begin
            if (age <= cfg.corr_window) begin
               tot_in = tot_ff + 1'b1;
               if (rd_ff[0]) inv_in = inv_ff + 1'b1;
            end
            if (age <= cfg.flood_window) fl_in = fl_ff + 1'b1;
            if (k_ff == fill_ff[slot_ff] && (age <= cfg.corr_window || tot_ff != '0))
               div_go = 1'b1;
         end
         ST_DIV: begin
            if (div_done || tot_ff == '0) begin
               if (ratio > cfg.corr_limit) begin
                  deg_in = 1'b1; fault_in = FAULT_CORRUPT;
               end
               if (ratio > max_ff) max_in = ratio;
               if ({10'd0, fl_ff} > {10'd0, cfg.flood_limit}) begin
                  if (!deg_ff && !(ratio > cfg.corr_limit)) fault_cnt_in = cnt_bump;
                  deg_in = 1'b1; fault_in = FAULT_FLOOD;
               end
               bus_in = bus_ff + 12'(fl_ff);
            end
         end
         ST_SLOT_END: begin
            if (bus_ff > 12'd2047) bus_in = 12'd2047;
            if (!last_slot) slot_in = slot_ff + 1'b1;
         end
         ST_DONE: begin
            cmd_pop = 1'b1;
            rsp_valid = cmd_data.eval;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.degraded          = deg_ff;
      rsp_data.fault_code        = fault_ff;
      rsp_data.fault_event_count = fault_cnt_ff;
      rsp_data.bus_frame_count   = bus_ff[10:0];
      rsp_data.peak_ratio        = max_ff;
      rsp_data.table_overflow    = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_addr] <= {cmd_data.now, cmd_data.invalid};
      if (mem_re) rd_ff <= ring_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_STAMP && (found_ff || have_free_ff)) begin
         id_ff[free_ff]   <= cmd_data.can_id;
         seen_ff[free_ff] <= cmd_data.now;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in; k_ff <= k_in; free_ff <= free_in;
      tot_ff <= tot_in; inv_ff <= inv_in; fl_ff <= fl_in;
      bus_ff <= bus_in; max_ff <= max_in; fault_ff <= fault_in; deg_ff <= deg_in;
      found_ff <= found_in; have_free_ff <= have_free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         drop_ff      <= '0;
         fault_cnt_ff <= '0;
         ovf_ff       <= 1'b0;
         for (int i = 0; i < ID_SLOTS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         drop_ff      <= drop_in;
         fault_cnt_ff <= fault_cnt_in;
         ovf_ff       <= ovf_in;
         if (state_ff == ST_STAMP && (found_ff || have_free_ff)) begin
            if (found_ff) begin
               head_ff[free_ff] <= head_ff[free_ff] + 1'b1;
               if (fill_ff[free_ff] != FILL_BITS'(RING_DEPTH))
                  fill_ff[free_ff] <= fill_ff[free_ff] + 1'b1;
            end else begin
               head_ff[free_ff] <= RING_BITS'(1);
               fill_ff[free_ff] <= FILL_BITS'(1);
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.degraded == (rsp_data.fault_code != FAULT_NONE)))
      else $error("bus state disagrees with fault");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> cmd_valid)
      else $error("back end working without a command");
   assert property (@(posedge clock) disable iff (reset)
      fault_cnt_ff >= $past(fault_cnt_ff) || $past(reset))
      else $error("fault counter went down");

endmodule

[rtl/can_bus_health_monitor_core.sv]
// CAN bus health monitor core.
// Request channel: drive req_data with start; a transfer happens at a rising
// edge where start is high and busy is low. mode 0 is a received frame, mode 1
// an evaluate tick. Frames produce no response; an evaluate tick produces one
// response, shown on rsp_data for one cycle with rsp_valid high. The receiver
// cannot stall the response.
// Config channel: csr_valid/csr_ready with csr_index and csr_wdata; index 0
// deadline, 1 corruption window, 2 ratio limit, 3 flood window, 4 flood limit.
// Unknown indexes are dropped. csr_ready is always high; write only when idle.
// Structure: front end classifies requests into a two-entry queue, back end
// sequencer executes them against the slot table and a 1024-entry ring RAM.
// A frame searches the slot table one slot at a time, then stamps its ring
// entry, or flags table overflow if it has no slot. An evaluate tick walks
// every slot; for a used slot it reads each ring entry in turn (a read state,
// then an accumulate state) and then waits for the ratio divider. Items run
// one after another; busy rises only once two requests are queued.
// Reset (synchronous): slots freed, counters zeroed, limits to defaults.
module can_bus_health_monitor_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cbhm_pkg::req_type req_data,
   output logic              rsp_valid,
   output cbhm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import cbhm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   assign csr_ready = 1'b1;

   // Register file update
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEADLINE:    cfg_in.deadline     = csr_wdata;
            CSR_CORR_WINDOW: cfg_in.corr_window  = csr_wdata;
            CSR_CORR_LIMIT:  cfg_in.corr_limit   = csr_wdata[16:0];
            CSR_FLOOD_WIN:   cfg_in.flood_window = csr_wdata;
            CSR_FLOOD_LIMIT: cfg_in.flood_limit  = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadline     <= 32'd100000;
         cfg_ff.corr_window  <= 32'd500000;
         cfg_ff.corr_limit   <= 17'd13107;
         cfg_ff.flood_window <= 32'd100000;
         cfg_ff.flood_limit  <= 7'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbhm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   cbhm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import cbhm_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;
   localparam int FRAME_SETTLE = 100;
   localparam int DRAIN_TAIL = 3000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   can_bus_health_monitor_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Health predictor: shadow of limits, slot table and stamp rings
   // ---------------------------------------------------------------
   logic [31:0] lim_deadline;
   logic [31:0] lim_corr_window;
   logic [16:0] lim_corr_ratio;
   logic [31:0] lim_flood_window;
   logic [6:0]  lim_flood_count;

   bit          slot_busy [ID_SLOTS];
   bit [28:0]   slot_owner [ID_SLOTS];
   bit [31:0]   slot_seen [ID_SLOTS];
   bit          slot_dropped [ID_SLOTS];
   bit [31:0]   stamp_time [ID_SLOTS][RING_DEPTH];
   bit          stamp_bad [ID_SLOTS][RING_DEPTH];
   int          stamp_head [ID_SLOTS];
   int          stamp_fill [ID_SLOTS];
   bit [31:0]   event_total;
   bit          table_full_seen;

   // health reports still owed by the core, oldest first
   rsp_type     health_q [$];
   int          fail_count;
   int          cycle_count;

   function automatic void bump_events();
      if (event_total != 32'hFFFF_FFFF) event_total++;
   endfunction

   function automatic void stamp_frame(req_type r);
      int hit;
      int spare;
      int h;
      hit = -1;
      spare = -1;
      for (int s = 0; s < ID_SLOTS; s++) begin
         if (slot_busy[s] && slot_owner[s] == r.can_id) begin
            hit = s;
            break;
         end
         if (!slot_busy[s] && spare < 0) spare = s;
      end
      if (hit < 0) begin
         if (spare < 0) begin
            table_full_seen = 1'b1;
            return;
         end
         hit = spare;
         slot_busy[hit] = 1'b1;
         slot_owner[hit] = r.can_id;
         slot_dropped[hit] = 1'b0;
         stamp_head[hit] = 0;
         stamp_fill[hit] = 0;
      end
      slot_seen[hit] = r.now_us;
      if (slot_dropped[hit]) begin
         // a returning node counts as an event
         slot_dropped[hit] = 1'b0;
         bump_events();
      end
      h = stamp_head[hit];
      stamp_time[hit][h] = r.now_us;
      stamp_bad[hit][h] = r.error_frame || (r.dlc > 4'd8);
      stamp_head[hit] = (h + 1) % RING_DEPTH;
      if (stamp_fill[hit] < RING_DEPTH) stamp_fill[hit]++;
   endfunction

   function automatic rsp_type assess_health(logic [31:0] now);
      rsp_type     res;
      bit          degraded;
      logic [1:0]  fault;
      longint      bus_total;
      longint      worst_ratio;
      longint      in_corr;
      longint      in_bad;
      longint      in_flood;
      longint      ratio;
      bit [31:0]   age;
      degraded = 1'b0;
      fault = FAULT_NONE;
      bus_total = 0;
      worst_ratio = 0;
      for (int s = 0; s < ID_SLOTS; s++) begin
         if (!slot_busy[s]) continue;
         age = now - slot_seen[s];
         if (!slot_dropped[s] && age > lim_deadline) begin
            slot_dropped[s] = 1'b1;
            degraded = 1'b1;
            fault = FAULT_DROPOUT;
            bump_events();
         end else if (slot_dropped[s]) begin
            degraded = 1'b1;
            fault = FAULT_DROPOUT;
         end
         in_corr = 0;
         in_bad = 0;
         in_flood = 0;
         for (int k = 0; k < stamp_fill[s]; k++) begin
            age = now - stamp_time[s][k];
            if (age <= lim_corr_window) begin
               in_corr++;
               if (stamp_bad[s][k]) in_bad++;
            end
            if (age <= lim_flood_window) in_flood++;
         end
         ratio = (in_corr > 0) ? (in_bad << 16) / in_corr : 0;
         if (ratio > lim_corr_ratio) begin
            degraded = 1'b1;
            fault = FAULT_CORRUPT;
         end
         if (ratio > worst_ratio) worst_ratio = ratio;
         if (in_flood > lim_flood_count) begin
            // flood only counts when nothing else was found on this walk
            if (!degraded) bump_events();
            degraded = 1'b1;
            fault = FAULT_FLOOD;
         end
         bus_total += in_flood;
      end
      if (bus_total > 2047) bus_total = 2047;
      res.degraded = degraded;
      res.fault_code = fault;
      res.fault_event_count = event_total;
      res.bus_frame_count = bus_total[10:0];
      res.peak_ratio = worst_ratio[16:0];
      res.table_overflow = table_full_seen;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Result checker: one report per strobe, oldest expectation first
   // ---------------------------------------------------------------
   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (health_q.size() == 0) begin
            $error("health report with nothing outstanding");
            fail_count++;
         end else begin
            rsp_type want;
            want = health_q[0];
            health_q.delete(0);
            compare_field("degraded", want.degraded, rsp_data.degraded);
            compare_field("fault_code", want.fault_code, rsp_data.fault_code);
            compare_field("fault_event_count", want.fault_event_count,
                          rsp_data.fault_event_count);
            compare_field("bus_frame_count", want.bus_frame_count,
                          rsp_data.bus_frame_count);
            compare_field("peak_ratio", want.peak_ratio,
                          rsp_data.peak_ratio);
            compare_field("table_overflow", want.table_overflow,
                          rsp_data.table_overflow);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------
   logic [31:0] now_t;       // running bus time
   logic [28:0] id_pool [24];
   int          idle_pct;

   // Drive one request; transfer happens at the first edge with busy low.
   task automatic send_req(req_type r);
      bit taken;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      if (r.mode) health_q = {health_q, assess_health(r.now_us)};
      else stamp_frame(r);
   endtask

   task automatic send_frame(logic [28:0] id, logic err, logic [3:0] dlc);
      req_type r;
      r.mode = 1'b0;
      r.now_us = now_t;
      r.can_id = id;
      r.error_frame = err;
      r.dlc = dlc;
      send_req(r);
   endtask

   task automatic send_eval();
      req_type r;
      r.mode = 1'b1;
      r.now_us = now_t;
      r.can_id = 29'($urandom);      // ignored by the core on a tick
      r.error_frame = 1'($urandom);
      r.dlc = 4'($urandom);
      send_req(r);
   endtask

   // With a chance of idle_pct percent, the sender idles for a random stretch, usually short, now and then long.
   task automatic maybe_idle();
      if ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 400)) @(negedge clock);
         else repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   // Hold off until every report has come and queued frames have retired.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (health_q.size() != 0) @(posedge clock);
      repeat (FRAME_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEADLINE:    lim_deadline = val;
         CSR_CORR_WINDOW: lim_corr_window = val;
         CSR_CORR_LIMIT:  lim_corr_ratio = val[16:0];
         CSR_FLOOD_WIN:   lim_flood_window = val;
         CSR_FLOOD_LIMIT: lim_flood_count = val[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_limits(logic [31:0] dl, logic [31:0] cw, logic [31:0] cr,
                              logic [31:0] fw, logic [31:0] fl);
      write_csr(CSR_DEADLINE, dl);
      write_csr(CSR_CORR_WINDOW, cw);
      write_csr(CSR_CORR_LIMIT, cr);
      write_csr(CSR_FLOOD_WIN, fw);
      write_csr(CSR_FLOOD_LIMIT, fl);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Default limits: empty table, dlc edges, error frame, dropout and return.
   task automatic test_defaults();
      idle_pct = 0;
      now_t = 32'd0;
      send_eval();                               // nothing in the table yet
      send_frame(29'd0, 1'b0, 4'd0);
      send_frame(29'h1FFF_FFFF, 1'b1, 4'd15);   // error frame, worst dlc
      send_frame(29'd5, 1'b0, 4'd8);            // largest valid dlc
      send_frame(29'd6, 1'b0, 4'd9);            // smallest invalid dlc
      send_eval();                               // corruption on two IDs
      now_t = now_t + 32'd100000;
      send_eval();                               // exactly at deadline
      now_t = now_t + 32'd1;
      send_eval();                               // past deadline: dropout
      send_eval();                               // still flagged, no new event
      send_frame(29'd0, 1'b0, 4'd3);            // return clears dropout
      send_eval();
   endtask

   // Time wrap, flood with a zero limit, unknown register indexes.
   task automatic test_wrap_flood();
      drain();
      load_limits(32'd1000, 32'd1000, 32'd0, 32'd1, 32'd0);
      write_csr(3'd5, $urandom);
      write_csr(3'd6, $urandom);
      write_csr(3'd7, $urandom);
      now_t = 32'hFFFF_FFF0;
      send_frame(29'd5, 1'b0, 4'd1);
      send_frame(29'd5, 1'b0, 4'd2);
      now_t = 32'h0000_0010;                     // age 0x20 across the wrap
      send_eval();
      send_frame(29'd6, 1'b1, 4'd4);
      send_eval();
   endtask

   // Pool of IDs: more than the table holds, so overflow is reached.
   task automatic build_pool();
      id_pool[0] = 29'd0;
      id_pool[1] = 29'h1FFF_FFFF;
      for (int i = 2; i < 24; i++) id_pool[i] = 29'($urandom);
   endtask

   task automatic random_phase(int count, int step, int idle);
      int pick;
      idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         maybe_idle();
         if ($urandom_range(0, 99) < 3) now_t = $urandom;   // time jump noise
         else now_t = now_t + $urandom_range(0, step);
         if (i == count / 2 && idle == 82) drain();         // sender waits out all reports
         if ($urandom_range(0, 3) == 0) begin
            send_eval();
         end else begin
            pick = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 11) : $urandom_range(0, 23);
            send_frame(id_pool[pick], ($urandom_range(0, 7) == 0), 4'($urandom));
         end
      end
   endtask

   task automatic test_random();
      build_pool();
      drain();
      load_limits(32'd2000, 32'd5000, 32'd13107, 32'd2000, 32'd8);
      random_phase(90, 300, 0);
      drain();
      load_limits(32'd0, 32'd0, 32'd0, 32'd1, 32'd0);                // low extremes
      random_phase(90, 2, 82);
      drain();
      load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF, 32'd64);
      random_phase(90, 1000, 13);
      drain();
      load_limits(32'd500, 32'd20000, 32'd30000, 32'd3000, 32'd20);
      random_phase(90, 100, 82);
      drain();
      load_limits(32'd100000, 32'd500000, 32'd13107, 32'd100000, 32'd50);
      random_phase(80, 5000, 0);
      drain();
      load_limits(32'd1000, 32'd1000, 32'd1, 32'd1000, 32'd64);
      random_phase(80, 50, 13);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      lim_deadline = 32'd100000;
      lim_corr_window = 32'd500000;
      lim_corr_ratio = 17'd13107;
      lim_flood_window = 32'd100000;
      lim_flood_count = 7'd50;
      event_total = '0;
      table_full_seen = 1'b0;
      for (int s = 0; s < ID_SLOTS; s++) begin
         slot_busy[s] = 1'b0;
         slot_dropped[s] = 1'b0;
         stamp_head[s] = 0;
         stamp_fill[s] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_wrap_flood();
      test_random();

      @(negedge clock);
      start <= 1'b0;
      while (health_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
